FILE: src/oaht_pkg.sv
// Shared constants for the open-addressing hash table.
// Operation and status codes, field widths and the default table size.
// No dependencies.
package oaht_pkg;

    // Default table size handed to the top level
    localparam int TABLE_SIZE_DEF = 16;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 31;
    localparam int START_W  = 5;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

    // Probe mode register values
    localparam logic MODE_LINEAR    = 1'b0;
    localparam logic MODE_QUADRATIC = 1'b1;

endpackage

FILE: src/oaht_home.sv
// Home slot unit: key mod TABLE_SIZE, four key bits per cycle, MSB first.
// Done pulses for one cycle with home valid once the last digit step is taken.
// Depends on oaht_pkg.
module oaht_home #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [oaht_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_SIZE)-1:0]  home
);
    import oaht_pkg::*;

    localparam int SW = $clog2(TABLE_SIZE);

    logic [31:0]   shift_reg, shift_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] rem_step;

    // Four restoring steps: r = (2r + bit) mod N, r stays below N
    always_comb
    begin
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = rem_reg;
        t = '0;
        for (int b = 3; b >= 0; b--)
        begin
            t = {r, shift_reg[28 + b]};
            if (t >= (SW+1)'(TABLE_SIZE))
            begin
                t = t - (SW+1)'(TABLE_SIZE);
            end
            r = t[SW-1:0];
        end
        rem_step = r;
    end

    // Sequencing of the eight digit steps
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = {1'b0, key};
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[27:0], 4'd0};
            rem_next   = rem_step;
            cnt_next   = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

FILE: src/oaht_ram.sv
// Slot memory: one write port and one read port, registered read data.
// Each word holds the used bit over the stored key.
// Depends on oaht_pkg for the key width.
module oaht_ram #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]     wr_addr,
    input  logic [oaht_pkg::KEY_W:0]          wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]     rd_addr,
    output logic [oaht_pkg::KEY_W:0]          rd_data
);
    import oaht_pkg::*;

    logic [KEY_W:0] mem [TABLE_SIZE];
    logic [KEY_W:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/open_addressing_hash_table.sv
// Open-addressing hash table, linear or quadratic probing, one item at a time.
// The home unit finds the home slot in its digit steps; probes below the start number
// are then skipped without a read, and each probed slot gets one memory read in S_PROBE
// and a decision in S_CHECK before the result goes to the output register.
// A new beat is taken once the previous result sits in the output register.
// Reset (rst_n, async low) clears control and probe mode, then a clearing pass
// zeroes each of the TABLE_SIZE slot memory words before the first beat is taken.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: func[1:0], key[32:2], start_probe[37:33], zero pad
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [oaht_pkg::IN_DATA_W-1:0]     s_tdata,
    // m_tdata: status[1:0], slot[5:2], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [oaht_pkg::OUT_DATA_W-1:0]    m_tdata,
    // probe_mode register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);
    import oaht_pkg::*;

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int IW = $clog2(TABLE_SIZE + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IW-1:0]       start_reg, start_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [SW-1:0]       delta_reg, delta_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Input beat fields
    logic [FUNC_W-1:0]   in_func;
    logic [KEY_W-1:0]    in_key;
    logic [START_W-1:0]  in_start;
    logic                in_accept;

    // Home unit and memory hookup
    logic                home_start;
    logic                home_done;
    logic [SW-1:0]       home_slot;
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    logic [KEY_W:0]      wr_data;
    logic                rd_en;
    logic [KEY_W:0]      rd_data;

    // Probe stepping
    logic [SW:0]         slot_sum;
    logic [SW-1:0]       slot_adv;
    logic [SW:0]         delta_sum;
    logic [SW-1:0]       delta_adv;
    logic                last_probe;
    logic                rd_used;
    logic                rd_match;
    logic                out_load;

    assign in_func   = s_tdata[1:0];
    assign in_key    = s_tdata[32:2];
    assign in_start  = s_tdata[37:33];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    oaht_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (key_next),
        .done  (home_done),
        .home  (home_slot)
    );

    oaht_ram #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    // Next probe slot: linear steps by one, quadratic by 2i+1, all mod N
    always_comb
    begin
        slot_sum = {1'b0, slot_reg} + ((mode_reg == MODE_QUADRATIC) ?
                   {1'b0, delta_reg} : (SW+1)'(1));
        if (slot_sum >= (SW+1)'(TABLE_SIZE))
        begin
            slot_sum = slot_sum - (SW+1)'(TABLE_SIZE);
        end
        slot_adv = slot_sum[SW-1:0];

        delta_sum = {1'b0, delta_reg} + (SW+1)'(2);
        if (delta_sum >= (SW+1)'(TABLE_SIZE))
        begin
            delta_sum = delta_sum - (SW+1)'(TABLE_SIZE);
        end
        delta_adv = delta_sum[SW-1:0];
    end

    assign last_probe = (idx_reg == IW'(TABLE_SIZE - 1));
    assign rd_used    = rd_data[KEY_W];
    assign rd_match   = (rd_data[KEY_W-1:0] == key_reg);
    assign rd_en      = (state_reg == S_PROBE) && !(idx_reg < start_reg);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // Main sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        delta_next      = delta_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        home_start      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '0;

        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end

        case (state_reg)
            // Zero one memory word per cycle after reset
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[SW-1:0];
                idx_next = idx_reg + IW'(1);
                if (last_probe)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = in_func;
                    key_next        = in_key;
                    res_status_next = STAT_MISSING;
                    res_slot_next   = '0;
                    if (in_func == FUNC_INSERT)
                    begin
                        start_next = '0;
                        home_start = 1'b1;
                        state_next = S_HOME;
                    end
                    else if ((in_func == FUNC_SEARCH || in_func == FUNC_REMOVE) &&
                             (32'(in_start) < 32'(TABLE_SIZE)))
                    begin
                        start_next = IW'(in_start);
                        home_start = 1'b1;
                        state_next = S_HOME;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_HOME:
            begin
                if (home_done)
                begin
                    slot_next  = home_slot;
                    idx_next   = '0;
                    delta_next = SW'(1);
                    state_next = S_PROBE;
                end
            end

            // Skip probes below the start number, else read the slot
            S_PROBE:
            begin
                if (idx_reg < start_reg)
                begin
                    idx_next   = idx_reg + IW'(1);
                    slot_next  = slot_adv;
                    delta_next = delta_adv;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            // Decide on the read word
            S_CHECK:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (!rd_used)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = {1'b1, key_reg};
                        res_status_next = STAT_OK;
                        res_slot_next   = slot_reg;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = STAT_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        slot_next  = slot_adv;
                        delta_next = delta_adv;
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    if (!rd_used)
                    begin
                        state_next = S_DONE;
                    end
                    else if (rd_match)
                    begin
                        res_status_next = STAT_OK;
                        res_slot_next   = slot_reg;
                        wr_en           = (func_reg == FUNC_REMOVE);
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        slot_next  = slot_adv;
                        delta_next = delta_adv;
                        state_next = S_PROBE;
                    end
                end
            end

            // Wait for room in the output register
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, SLOT_W'(res_slot_reg), res_status_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= MODE_LINEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        start_reg      <= start_next;
        slot_reg       <= slot_next;
        delta_reg      <= delta_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result that is not success carries slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[5:2] == 4'd0))
        else $error("nonzero slot with failing status");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == STAT_OK || m_tdata[1:0] == STAT_FULL ||
                      m_tdata[1:0] == STAT_MISSING))
        else $error("undefined status code");

    // One item at a time: no beat taken right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while busy");

    // Probe counter stays inside the table while checking a slot
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (idx_reg < IW'(TABLE_SIZE)))
        else $error("probe counter out of range");

endmodule
